>>> hw/rtl/dfir_pkg.sv
// Shared types and constants for the decimating FIR filter.
package dfir_pkg;

   localparam int MAX_TAPS      = 16;
   localparam int CNT_W         = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int DATA_W        = 32;
   localparam int PROD_W        = 2 * DATA_W;
   localparam int COEF_IDX_W    = 4;
   localparam int TAP_COUNT_W   = 5;
   localparam int DECIM_W       = 4;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 5;
   localparam int PRODUCT_SHIFT = 17;

   // Added to a negative product so the arithmetic shift truncates toward zero
   localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'((64'd1 << PRODUCT_SHIFT) - 64'd1);

   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_COEF   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_TAP_COUNT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECIMATION = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SCALE,
      ST_SUM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic shift_en;
      logic mul_en;
      logic scale_en;
      logic acc_en;
   } cell_ctrl_type;

endpackage

>>> hw/rtl/dfir_cell.sv
// One tap cell: delay stage, coefficient, product, scaled term and partial sum.
module dfir_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  dfir_pkg::cell_ctrl_type       ctrl,
   input  logic                          tap_on,
   input  logic                          coef_we,
   input  logic [dfir_pkg::DATA_W-1:0]   coef_wdata,
   input  logic [dfir_pkg::DATA_W-1:0]   sample_prev,
   input  logic [dfir_pkg::DATA_W-1:0]   psum_prev,
   output logic [dfir_pkg::DATA_W-1:0]   sample_out,
   output logic [dfir_pkg::DATA_W-1:0]   psum_out
);
   import dfir_pkg::*;

   logic [DATA_W-1:0] delay_ff, delay_in;
   logic [DATA_W-1:0] coef_ff,  coef_in;
   logic [PROD_W-1:0] prod_ff,  prod_in;
   logic [DATA_W-1:0] term_ff,  term_in;
   logic [DATA_W-1:0] psum_ff,  psum_in;
   logic [PROD_W-1:0] biased;
   logic signed [PROD_W-1:0] prod_full;

   always_comb begin
      delay_in  = ctrl.shift_en ? sample_prev : delay_ff;
      coef_in   = coef_we ? coef_wdata : coef_ff;
      // full-width signed product
      prod_full = $signed(coef_ff) * $signed(delay_ff);
      prod_in   = ctrl.mul_en ? prod_full : prod_ff;
      biased    = prod_ff + (prod_ff[PROD_W-1] ? ROUND_BIAS : '0);
      if (ctrl.scale_en) begin
         term_in = tap_on ? biased[PRODUCT_SHIFT +: DATA_W] : '0;
      end else begin
         term_in = term_ff;
      end
      // ripple the running sum one cell per cycle
      psum_in  = ctrl.acc_en ? (psum_prev + term_ff) : psum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
      end else begin
         delay_ff <= delay_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
      prod_ff <= prod_in;
      term_ff <= term_in;
      psum_ff <= psum_in;
   end

   assign sample_out = delay_ff;
   assign psum_out   = psum_ff;

endmodule

>>> hw/rtl/decimating_fir_filter.sv
// Top level of the decimating FIR filter: control, registers and the tap cell chain.
//
// Decimating direct-form FIR filter built as a chain of tap cells. A request beat with
// action set writes one coefficient. A sample beat steps the decimation phase; a dropped
// sample leaves the block idle. A kept sample shifts the delay line, then every cell
// multiplies and scales its product by 1/131072 toward zero, and the partial sum ripples
// through the chain one cell per cycle. req_stall stays high through ST_MUL, ST_SCALE,
// ST_SUM and ST_DONE; ST_DONE waits while the output register is still held by rsp_stall.
// The result sits in an output register, so the next beat is taken while it waits on
// rsp_stall. csr index 0 sets the tap count (above MAX_TAPS means all taps), index 1 the
// decimation (0 acts as 1); write them only while the block is idle.
module decimating_fir_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic [dfir_pkg::COEF_IDX_W-1:0]   req_coef_index,
   input  logic signed [dfir_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [dfir_pkg::DATA_W-1:0] rsp_filtered_value,
   input  logic                              csr_we,
   input  logic [dfir_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dfir_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dfir_pkg::*;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [TAP_COUNT_W-1:0]  tap_count_ff, tap_count_in;
   logic [DECIM_W-1:0]      decim_ff, decim_in;
   logic [DECIM_W-1:0]      phase_ff, phase_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]       rsp_value_ff, rsp_value_in;

   cell_ctrl_type           ctrl;
   logic                    req_take;
   logic [DECIM_W-1:0]      stride;
   logic [DECIM_W-1:0]      phase_step;

   logic [DATA_W-1:0]       sample_chain [MAX_TAPS+1];
   logic [DATA_W-1:0]       psum_chain   [MAX_TAPS+1];
   logic [MAX_TAPS-1:0]     tap_on;
   logic [MAX_TAPS-1:0]     coef_we;

   assign req_take   = req_valid && !req_stall;
   assign stride     = (decim_ff == '0) ? DECIM_W'(1) : decim_ff;
   assign phase_step = phase_ff + DECIM_W'(1);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      phase_in      = phase_ff;
      tap_count_in  = tap_count_ff;
      decim_in      = decim_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      ctrl          = '0;
      req_stall     = (state_ff != ST_IDLE);

      if (csr_we) begin
         case (csr_index)
            CSR_TAP_COUNT:  tap_count_in = csr_wdata[TAP_COUNT_W-1:0];
            CSR_DECIMATION: decim_in     = csr_wdata[DECIM_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_action == ACTION_SAMPLE) begin
               phase_in = (phase_step >= stride) ? '0 : phase_step;
               if (phase_ff == '0) begin
                  ctrl.shift_en = 1'b1;
                  state_in      = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            ctrl.mul_en = 1'b1;
            state_in    = ST_SCALE;
         end
         ST_SCALE: begin
            ctrl.scale_en = 1'b1;
            cnt_in        = '0;
            state_in      = ST_SUM;
         end
         ST_SUM: begin
            ctrl.acc_en = 1'b1;
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MAX_TAPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold the sum until the output register frees up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = psum_chain[MAX_TAPS];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         tap_count_ff <= TAP_COUNT_W'(1);
         decim_ff     <= DECIM_W'(1);
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         tap_count_ff <= tap_count_in;
         decim_ff     <= decim_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign sample_chain[0] = req_value;
   assign psum_chain[0]   = '0;

   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
      assign tap_on[k]  = (32'(tap_count_ff) > 32'(k));
      assign coef_we[k] = req_take && (req_action == ACTION_COEF)
                          && (32'(req_coef_index) == 32'(k));

      dfir_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .tap_on      (tap_on[k]),
         .coef_we     (coef_we[k]),
         .coef_wdata  (req_value),
         .sample_prev (sample_chain[k]),
         .psum_prev   (psum_chain[k]),
         .sample_out  (sample_chain[k+1]),
         .psum_out    (psum_chain[k+1])
      );
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_value_ff;

endmodule

>>> test/tb.sv
// Self-checking testbench for the decimating FIR filter: directed and random beats, checked in order.
`timescale 1ns / 100ps

module tb;
   import dfir_pkg::*;

   typedef struct {
      logic                  action;
      logic [COEF_IDX_W-1:0] index;
      logic [DATA_W-1:0]     value;
   } fir_beat_type;

   localparam int     RUN_LIMIT   = 400000;
   localparam int     SETTLE      = MAX_TAPS + 12;
   localparam int     ITEM_TARGET = 1400;
   localparam longint SCALE       = longint'(1) << PRODUCT_SHIFT;

   logic                         clock          = 1'b0;
   logic                         reset          = 1'b1;
   logic                         req_valid      = 1'b0;
   logic                         req_stall;
   logic                         req_action     = ACTION_SAMPLE;
   logic [COEF_IDX_W-1:0]        req_coef_index = '0;
   logic signed [DATA_W-1:0]     req_value      = '0;
   logic                         rsp_valid;
   logic                         rsp_stall      = 1'b0;
   logic signed [DATA_W-1:0]     rsp_filtered_value;
   logic                         csr_we         = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index      = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata      = '0;

   // Shadow of the filter state
   logic signed [DATA_W-1:0]     coef_tab   [MAX_TAPS];
   logic signed [DATA_W-1:0]     delay_taps [MAX_TAPS];
   logic [DECIM_W-1:0]           dec_phase;
   logic [TAP_COUNT_W-1:0]       cfg_taps;
   logic [DECIM_W-1:0]           cfg_decim;

   fir_beat_type                 beat_queue [$];
   logic signed [DATA_W-1:0]     filtered_q [$];

   logic                         src_idle_en  = 1'b0;
   logic                         snk_stall_en = 1'b0;
   logic                         req_taken    = 1'b0;
   logic                         rsp_taken    = 1'b0;
   int                           req_gap      = 0;
   int                           stall_left   = 0;

   int                           cycle_count  = 0;
   int                           errors       = 0;
   int                           samples_sent = 0;
   int                           kept_count   = 0;
   int                           coef_writes  = 0;
   int                           checked      = 0;
   int                           settings     = 0;
   int                           pushed       = 0;

   decimating_fir_filter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_coef_index     (req_coef_index),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_value (rsp_filtered_value),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("decimating_fir_filter verification failed");
         $finish;
      end
   end

   // Update the shadow state for one accepted beat; queue the output of a kept sample.
   function automatic void filter_beat(fir_beat_type b);
      int unsigned        stride;
      int unsigned        active;
      int                 k;
      logic               keep;
      logic [DECIM_W-1:0] nxt;
      logic [DATA_W-1:0]  acc;
      longint             quot;
      if (b.action == ACTION_COEF) begin
         coef_tab[b.index] = b.value;
         coef_writes++;
         return;
      end
      samples_sent++;
      stride = (cfg_decim == 0) ? 1 : cfg_decim;
      keep = (dec_phase == 0);
      nxt = dec_phase + 1'b1;
      dec_phase = (nxt >= stride) ? '0 : nxt;
      if (!keep)
         return;
      kept_count++;
      for (k = MAX_TAPS - 1; k > 0; k--)
         delay_taps[k] = delay_taps[k - 1];
      delay_taps[0] = b.value;
      active = (cfg_taps > MAX_TAPS) ? MAX_TAPS : cfg_taps;
      acc = '0;
      for (k = 0; k < active; k++) begin
         quot = (longint'(coef_tab[k]) * longint'(delay_taps[k])) / SCALE;
         acc += quot[DATA_W-1:0];
      end
      filtered_q.push_back(acc);
   endfunction

   // Request side: record accepted beats at the rising edge.
   always @(posedge clock) begin
      fir_beat_type b;
      if (!reset && req_valid && !req_stall) begin
         b.action = req_action;
         b.index = req_coef_index;
         b.value = req_value;
         filter_beat(b);
         req_taken = 1'b1;
      end
   end

   // Request side: present the next beat at the falling edge once the last one is taken.
   always @(negedge clock) begin
      fir_beat_type b;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (beat_queue.size() > 0) begin
            b = beat_queue.pop_front();
            req_action <= b.action;
            req_coef_index <= b.index;
            req_value <= b.value;
            req_valid <= 1'b1;
            req_gap = src_idle_en ? $urandom_range(0, 3) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: check each accepted beat against the oldest expected output.
   always @(posedge clock) begin
      logic signed [DATA_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (filtered_q.size() == 0) begin
            $error("filtered_value: expected none, actual %0d", rsp_filtered_value);
            errors++;
         end else begin
            want = filtered_q.pop_front();
            checked++;
            if (rsp_filtered_value !== want) begin
               $error("filtered_value: expected %0d, actual %0d", want, rsp_filtered_value);
               errors++;
            end
         end
         rsp_taken = 1'b1;
      end
   end

   // Result side: hold stall for a drawn number of cycles that a result is waiting.
   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         stall_left = snk_stall_en ? $urandom_range(0, 3) : 0;
      end
      if (rsp_valid && stall_left > 0)
         stall_left--;
      rsp_stall <= !reset && (stall_left > 0);
   end

   task automatic wait_idle();
      while (beat_queue.size() != 0 || req_valid || filtered_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_TAP_COUNT)
         cfg_taps = data;
      else
         cfg_decim = data[DECIM_W-1:0];
   endtask

   task automatic new_setting(int taps_w, int decim_w);
      wait_idle();
      write_csr(CSR_TAP_COUNT, CSR_DATA_W'(taps_w));
      write_csr(CSR_DECIMATION, CSR_DATA_W'(decim_w));
      src_idle_en = ($urandom_range(0, 3) != 0);
      snk_stall_en = ($urandom_range(0, 3) != 0);
      settings++;
   endtask

   task automatic push_beat(logic action, int idx, logic [DATA_W-1:0] value);
      fir_beat_type b;
      b.action = action;
      b.index = COEF_IDX_W'(idx);
      b.value = value;
      beat_queue.push_back(b);
      pushed++;
   endtask

   task automatic push_random(int count, int coef_pct);
      int                i;
      logic              action;
      logic [DATA_W-1:0] value;
      for (i = 0; i < count; i++) begin
         action = ($urandom_range(0, 99) < coef_pct) ? ACTION_COEF : ACTION_SAMPLE;
         case ($urandom_range(0, 7))
            0: value = 32'h7FFF_FFFF;
            1: value = 32'h8000_0000;
            2: value = '0;
            3: value = '1;
            4: value = DATA_W'($urandom_range(0, 4095)) - 32'd2048;
            default: value = $urandom;
         endcase
         push_beat(action, $urandom_range(0, MAX_TAPS - 1), value);
      end
   endtask

   initial begin
      int k;
      for (k = 0; k < MAX_TAPS; k++) begin
         coef_tab[k] = '0;
         delay_taps[k] = '0;
      end
      dec_phase = '0;
      cfg_taps = TAP_COUNT_W'(1);
      cfg_decim = DECIM_W'(1);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill the whole coefficient table before any sample
      for (k = 0; k < MAX_TAPS; k++) begin
         if (k == 0)
            push_beat(ACTION_COEF, k, 32'h7FFF_FFFF);
         else if (k == MAX_TAPS - 1)
            push_beat(ACTION_COEF, k, 32'h8000_0000);
         else
            push_beat(ACTION_COEF, k, $urandom);
      end
      push_beat(ACTION_SAMPLE, 0, 32'h7FFF_FFFF);
      push_beat(ACTION_SAMPLE, 15, 32'h8000_0000);
      push_beat(ACTION_SAMPLE, 3, 32'h0000_0000);
      push_beat(ACTION_SAMPLE, 9, 32'hFFFF_FFFF);
      push_beat(ACTION_SAMPLE, 0, 32'h0000_0001);
      push_beat(ACTION_SAMPLE, 0, 32'h0002_0000);
      push_beat(ACTION_COEF, 0, 32'h8000_0000);
      push_beat(ACTION_SAMPLE, 0, 32'h8000_0000);
      push_beat(ACTION_SAMPLE, 0, 32'h7FFF_FFFF);

      new_setting(16, 1);
      push_random(120, 15);
      // no active taps
      new_setting(0, 1);
      push_random(40, 20);
      // tap count above the table size, decimation zero
      new_setting(31, 0);
      push_random(100, 15);
      // leave the phase at 12 of 15, then drop the stride below it
      new_setting(17, 15);
      push_random(72, 0);
      new_setting(8, 3);
      push_random(80, 15);
      // upper csr bit is outside the decimation field
      new_setting(16, 23);
      push_random(100, 10);

      while (pushed < ITEM_TARGET) begin
         new_setting($urandom_range(0, 31), $urandom_range(0, 31));
         push_random($urandom_range(40, 120), $urandom_range(5, 25));
      end
      wait_idle();

      $display("Covered %0d samples (%0d kept) and %0d coefficient writes over %0d settings.",
               samples_sent, kept_count, coef_writes, settings);
      $display("Checked %0d filter outputs, %0d mismatches.", checked, errors);
      if (errors == 0)
         $display("decimating_fir_filter verification clean");
      else
         $display("decimating_fir_filter verification failed");
      $finish;
   end

endmodule
